// ===== rtl/core/srt_pkg.sv =====
package srt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUTCNT_W = 5;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_DELETED   = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_FULL      = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // Broadcast to every cell.
  typedef struct packed {
    cell_mode_e mode;
    rec_t       rec;
  } cell_cmd_t;

  // Where a cell sits relative to the fill count.
  typedef struct packed {
    logic occupied;
    logic at_fill;
    logic tail;
  } cell_pos_t;

endpackage

// ===== rtl/core/srt_if.sv =====
interface srt_in_if;
  import srt_pkg::*;

  logic               valid;
  logic               ready;
  logic [0:0]         opcode;
  logic [KEY_W-1:0]   record_key;
  logic [SCORE_W-1:0] record_score;

  modport source (output valid, output opcode, output record_key, output record_score,
                  input ready);
  modport sink   (input valid, input opcode, input record_key, input record_score,
                  output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OUTCNT_W-1:0] entry_count;
  logic                entry_valid;
  logic [KEY_W-1:0]    entry_key;
  logic [SCORE_W-1:0]  entry_score;
  logic                last;

  modport source (output valid, output status, output entry_count, output entry_valid,
                  output entry_key, output entry_score, output last, input ready);
  modport sink   (input valid, input status, input entry_count, input entry_valid,
                  input entry_key, input entry_score, input last, output ready);
endinterface

// ===== rtl/core/sorted_record_table_unit.sv =====
// Sorted record table: a chain of CAPACITY cells, one record each, kept in key order.
// An operation is applied in the cycle its word is accepted; the listing starts in the
// next cycle and gives one word per record then held (one word when empty), as the chain
// rotates one record to the head per output word; no operation is taken before the last
// word is accepted. Reset clears the fill count and control; record contents are kept.
module sorted_record_table_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  srt_in_if.sink    in_i,
  srt_out_if.source out_o
);
  import srt_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    pos_q, pos_d;

  cell_cmd_t           cmd;
  cell_pos_t           cpos [CAPACITY];
  rec_t                rec  [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] hit;
  logic                found;
  logic                last;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cpos[i].occupied = CNT_W'(i) < cnt_q;
    assign cpos[i].at_fill  = CNT_W'(i) == cnt_q;
    assign cpos[i].tail     = CNT_W'(i + 1) == cnt_q;

    srt_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (cpos[i]),
      .prev_ge_i  ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
      .left_rec_i (rec[(i == 0) ? 0 : i - 1]),
      .right_rec_i(rec[(i == CAPACITY - 1) ? 0 : i + 1]),
      .head_rec_i (rec[0]),
      .rec_o      (rec[i]),
      .ge_o       (ge[i]),
      .hit_o      (hit[i])
    );
  end

  assign found = |hit;
  assign last  = (cnt_q == '0) || (CNT_W'(pos_q) == cnt_q - CNT_W'(1));

  assign out_o.status      = status_q;
  assign out_o.entry_count = OUTCNT_W'(cnt_q);
  assign out_o.entry_valid = cnt_q != '0;
  assign out_o.entry_key   = (cnt_q != '0) ? rec[0].key : '0;
  assign out_o.entry_score = (cnt_q != '0) ? rec[0].score : '0;
  assign out_o.last        = last;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    status_d      = status_q;
    pos_d         = pos_q;
    cmd.mode      = CM_HOLD;
    cmd.rec.key   = in_i.record_key;
    cmd.rec.score = in_i.record_score;
    in_i.ready    = 1'b0;
    out_o.valid   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_STREAM;
          pos_d   = '0;
          if (in_i.opcode == OP_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = STS_FULL;
            end else begin
              cmd.mode = CM_INSERT;
              cnt_d    = cnt_q + CNT_W'(1);
              status_d = STS_INSERTED;
            end
          end else if (cnt_q == '0) begin
            status_d = STS_EMPTY;
          end else if (found) begin
            cmd.mode = CM_DELETE;
            cnt_d    = cnt_q - CNT_W'(1);
            status_d = STS_DELETED;
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
      end
      ST_STREAM: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          // a full turn of the ring leaves the table in its original order
          if (cnt_q != '0) begin
            cmd.mode = CM_ROTATE;
          end
          if (last) begin
            state_d = ST_IDLE;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      status_q <= STS_INSERTED;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      pos_q    <= pos_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_cnt_hold_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |=> $stable(cnt_q))
    else $error("fill count changed during listing");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.opcode == OP_INSERT) && (cnt_q != CNT_W'(CAPACITY)))
      |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("accepted insert did not add a record");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> (state_q == ST_IDLE))
    else $error("listing continued after last word");

endmodule

// ===== rtl/core/srt_cell.sv =====
module srt_cell (
  input  logic              clk_i,
  input  srt_pkg::cell_cmd_t cmd_i,
  input  srt_pkg::cell_pos_t pos_i,
  input  logic              prev_ge_i,
  input  srt_pkg::rec_t     left_rec_i,
  input  srt_pkg::rec_t     right_rec_i,
  input  srt_pkg::rec_t     head_rec_i,
  output srt_pkg::rec_t     rec_o,
  output logic              ge_o,
  output logic              hit_o
);
  import srt_pkg::*;

  rec_t rec_q, rec_d;

  assign ge_o  = pos_i.occupied && (rec_q.key >= cmd_i.rec.key);
  // Keys are sorted, so the first match is the one whose left neighbor is below the key.
  assign hit_o = pos_i.occupied && (rec_q.key == cmd_i.rec.key) && !prev_ge_i;
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    unique case (cmd_i.mode)
      CM_HOLD: ;
      CM_INSERT: begin
        if (prev_ge_i) begin
          rec_d = left_rec_i;
        end else if (ge_o || pos_i.at_fill) begin
          rec_d = cmd_i.rec;
        end
      end
      CM_DELETE: begin
        // close the gap from the matching record onward
        if (ge_o && !pos_i.tail) begin
          rec_d = right_rec_i;
        end
      end
      CM_ROTATE: begin
        rec_d = pos_i.tail ? head_rec_i : right_rec_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule
